FILE: rtl/vertex_normal_accumulator_unit_defines.svh
// assertion macros for the vertex normal accumulator
// needs clk and rst_n in the scope that uses them
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define VNA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// next-cycle implication
`define VNA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

FILE: rtl/vna_pkg.sv
// shared widths and command codes of the vertex normal accumulator
// no dependencies
`default_nettype none
package vna_pkg;
    localparam int ADDR_W   = 10;
    localparam int CNT_W    = 11;
    localparam int MAX_VERT = 1024;
    localparam int COORD_W  = 24;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int SUM_W    = 64;
    localparam int CROSS_W  = 2 * COORD_W + 3;
    localparam int MAG_W    = 30;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int NORM_W   = 16;
    localparam int Q_W      = 15;
    localparam int LEN_W    = 31;
    localparam int FRAC_N   = 14;
    localparam int ONE_Q14  = 16384;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_TRI   = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_CLEAR = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/vertex_normal_accumulator_unit.sv
// area-weighted vertex normal accumulator: position and sum memories,
// bit-serial multiplier, bit-serial square root and divider
// depends on vna_pkg and vertex_normal_accumulator_unit_defines.svh
//
// usage: drive cmd and the fields with start high; the transaction is taken
// at a rising edge where busy is low. load, clear, and a triangle with a
// corner at or above the loaded count keep busy low and give no result.
// a triangle does three position reads, six shift-add products on one serial
// multiplier, then three read-modify-writes of the sum memory.
// a read gives one result, marked by done for one cycle. an out-of-range
// read answers in the cycle after it is taken, a read of a zero sum after the
// states S_RRD and S_RMAG. otherwise it runs the normalizing shifts
// (0 to 34, one bit per cycle), the serial multiplier (three squares),
// the 32-step square root and three 15-step divisions.
// the receiver cannot stall: done pulses once and the outputs hold after.
// reset empties the mesh; memory contents stay undefined until loaded.
`default_nettype none
`include "vertex_normal_accumulator_unit_defines.svh"
module vertex_normal_accumulator_unit
    import vna_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire cmd_t                       cmd,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic signed [COORD_W-1:0]  pos_z,
    input  wire logic [ADDR_W-1:0]          corner_a,
    input  wire logic [ADDR_W-1:0]          corner_b,
    input  wire logic [ADDR_W-1:0]          corner_c,
    input  wire logic [ADDR_W-1:0]          read_index,
    output logic                            done,
    output logic signed [NORM_W-1:0]        norm_x,
    output logic signed [NORM_W-1:0]        norm_y,
    output logic signed [NORM_W-1:0]        norm_z,
    output logic                            used_fallback,
    output logic                            out_of_range
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TRA  = 5'd1;
    localparam logic [4:0] S_TRB  = 5'd2;
    localparam logic [4:0] S_TRC  = 5'd3;
    localparam logic [4:0] S_EDGE = 5'd4;
    localparam logic [4:0] S_TMLD = 5'd5;
    localparam logic [4:0] S_TMUL = 5'd6;
    localparam logic [4:0] S_SRD  = 5'd7;
    localparam logic [4:0] S_SWR  = 5'd8;
    localparam logic [4:0] S_RRD  = 5'd9;
    localparam logic [4:0] S_RMAG = 5'd10;
    localparam logic [4:0] S_NORM = 5'd11;
    localparam logic [4:0] S_SLD  = 5'd12;
    localparam logic [4:0] S_SQ   = 5'd13;
    localparam logic [4:0] S_SQRT = 5'd14;
    localparam logic [4:0] S_DLD  = 5'd15;
    localparam logic [4:0] S_DIV  = 5'd16;

    localparam int MCNT_W = $clog2(MAG_W);
    localparam int DCNT_W = $clog2(Q_W);
    localparam int NUM_W  = MAG_W + FRAC_N + 1;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic signed [CROSS_W-1:0] b);
        logic [SUM_W:0] s;
        begin
            s = {a[SUM_W-1], a} + (SUM_W+1)'(signed'(b));
            if (s[SUM_W] != s[SUM_W-1])
            begin
                sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sat_add = s[SUM_W-1:0];
            end
        end
    endfunction

    function automatic logic [SUM_W-1:0] mag64(input logic [SUM_W-1:0] a);
        begin
            mag64 = a[SUM_W-1] ? (~a + 1'b1) : a;
        end
    endfunction

    function automatic logic [MAG_W-1:0] mag_edge(input logic signed [EDGE_W-1:0] e);
        logic [EDGE_W-1:0] m;
        begin
            m = e[EDGE_W-1] ? (~e + 1'b1) : e;
            mag_edge = MAG_W'(m);
        end
    endfunction

    logic [4:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       done_reg, done_next;

    logic [3*COORD_W-1:0]       pos_mem [MAX_VERT];
    logic [3*COORD_W-1:0]       pos_rd_reg;
    logic [3*SUM_W-1:0]         sum_mem [MAX_VERT];
    logic [3*SUM_W-1:0]         sum_rd_reg;
    logic                       pos_we, sum_we;
    logic [ADDR_W-1:0]          pos_ra, sum_ra, sum_wa;
    logic [3*SUM_W-1:0]         sum_wd;

    logic [ADDR_W-1:0]          ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next, corner_sel;
    logic signed [COORD_W-1:0]  ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [EDGE_W-1:0]   e0x_reg, e0x_next, e0y_reg, e0y_next, e0z_reg, e0z_next;
    logic signed [EDGE_W-1:0]   e1x_reg, e1x_next, e1y_reg, e1y_next, e1z_reg, e1z_next;
    logic signed [COORD_W-1:0]  rdx, rdy, rdz;
    logic signed [EDGE_W-1:0]   opa, opb;
    logic [2:0]                 k_reg, k_next;
    logic [1:0]                 j_reg, j_next;

    logic [PROD_W-1:0]          mcand_reg, mcand_next, macc_reg, macc_next, prod_c;
    logic [MAG_W-1:0]           mplier_reg, mplier_next;
    logic [MCNT_W-1:0]          mcnt_reg, mcnt_next;
    logic                       msign_reg, msign_next;
    logic signed [CROSS_W-1:0]  n_reg [3];
    logic signed [CROSS_W-1:0]  n_next [3];
    logic signed [CROSS_W-1:0]  pterm;

    logic [SUM_W-1:0]           mg_reg [3];
    logic [SUM_W-1:0]           mg_next [3];
    logic [2:0]                 sg_reg, sg_next;
    logic [SUM_W-1:0]           m01, mmax, mg_sel;
    logic [SUM_W-1:0]           v_reg, v_next, res_reg, res_next, bit_reg, bit_next, strial;
    logic [LEN_W-1:0]           rem_reg, rem_next, len;
    logic [LEN_W:0]             dtrial;
    logic                       dge;
    logic [Q_W-1:0]             numsh_reg, numsh_next, q_reg, q_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic [NUM_W-1:0]           dnum;
    logic [NORM_W-1:0]          qo;
    logic signed [NORM_W-1:0]   o_reg [3];
    logic signed [NORM_W-1:0]   o_next [3];
    logic                       fb_reg, fb_next, oor_reg, oor_next;

    always_comb
    begin
        rdx = signed'(pos_rd_reg[COORD_W-1:0]);
        rdy = signed'(pos_rd_reg[2*COORD_W-1:COORD_W]);
        rdz = signed'(pos_rd_reg[3*COORD_W-1:2*COORD_W]);
        unique case (j_reg)
            2'd0:    corner_sel = ca_reg;
            2'd1:    corner_sel = cb_reg;
            default: corner_sel = cc_reg;
        endcase
        unique case (k_reg)
            3'd0:    begin opa = e0y_reg; opb = e1z_reg; end
            3'd1:    begin opa = e0z_reg; opb = e1y_reg; end
            3'd2:    begin opa = e0z_reg; opb = e1x_reg; end
            3'd3:    begin opa = e0x_reg; opb = e1z_reg; end
            3'd4:    begin opa = e0x_reg; opb = e1y_reg; end
            default: begin opa = e0y_reg; opb = e1x_reg; end
        endcase
        mg_sel = (k_reg == 3'd0) ? mg_reg[0] : (k_reg == 3'd1) ? mg_reg[1] : mg_reg[2];
        prod_c = macc_reg + (mplier_reg[0] ? mcand_reg : '0);
        pterm  = msign_reg ? -signed'(prod_c[CROSS_W-1:0]) : signed'(prod_c[CROSS_W-1:0]);
        if (k_reg[0])
        begin
            pterm = -pterm;
        end
        m01    = (mg_reg[0] > mg_reg[1]) ? mg_reg[0] : mg_reg[1];
        mmax   = (m01 > mg_reg[2]) ? m01 : mg_reg[2];
        strial = res_reg + bit_reg;
        len    = res_reg[LEN_W-1:0];
        dtrial = {rem_reg, numsh_reg[Q_W-1]};
        dge    = dtrial >= {1'b0, len};
        dnum   = NUM_W'({mg_sel[MAG_W-1:0], {FRAC_N{1'b0}}}) + NUM_W'(res_reg[LEN_W-1:1]);
        q_next = {q_reg[Q_W-2:0], dge};
        qo     = {1'b0, q_next};
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        cc_next     = cc_reg;
        idx_next    = idx_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        e0x_next    = e0x_reg;
        e0y_next    = e0y_reg;
        e0z_next    = e0z_reg;
        e1x_next    = e1x_reg;
        e1y_next    = e1y_reg;
        e1z_next    = e1z_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        macc_next   = macc_reg;
        mcnt_next   = mcnt_reg;
        msign_next  = msign_reg;
        n_next      = n_reg;
        mg_next     = mg_reg;
        sg_next     = sg_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        rem_next    = rem_reg;
        numsh_next  = numsh_reg;
        dcnt_next   = dcnt_reg;
        o_next      = o_reg;
        fb_next     = fb_reg;
        oor_next    = oor_reg;
        pos_we      = 1'b0;
        sum_we      = 1'b0;
        sum_wa      = corner_sel;
        sum_wd      = {sat_add(sum_rd_reg[3*SUM_W-1:2*SUM_W], n_reg[2]),
                       sat_add(sum_rd_reg[2*SUM_W-1:SUM_W], n_reg[1]),
                       sat_add(sum_rd_reg[SUM_W-1:0], n_reg[0])};
        pos_ra      = (state_reg == S_TRA) ? ca_reg : (state_reg == S_TRB) ? cb_reg : cc_reg;
        sum_ra      = (state_reg == S_RRD) ? idx_reg : corner_sel;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_VERT))
                            begin
                                pos_we   = 1'b1;
                                sum_we   = 1'b1;
                                sum_wa   = cnt_reg[ADDR_W-1:0];
                                sum_wd   = '0;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_TRI:
                        begin
                            ca_next = corner_a;
                            cb_next = corner_b;
                            cc_next = corner_c;
                            if ({1'b0, corner_a} < cnt_reg && {1'b0, corner_b} < cnt_reg
                                && {1'b0, corner_c} < cnt_reg)
                            begin
                                state_next = S_TRA;
                            end
                        end
                        CMD_READ:
                        begin
                            idx_next = read_index;
                            if ({1'b0, read_index} < cnt_reg)
                            begin
                                state_next = S_RRD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                oor_next  = 1'b1;
                                fb_next   = 1'b0;
                                o_next[0] = '0;
                                o_next[1] = '0;
                                o_next[2] = '0;
                            end
                        end
                        default:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            S_TRA:
            begin
                state_next = S_TRB;
            end
            S_TRB:
            begin
                ax_next    = rdx;
                ay_next    = rdy;
                az_next    = rdz;
                state_next = S_TRC;
            end
            S_TRC:
            begin
                e0x_next   = EDGE_W'(rdx) - EDGE_W'(ax_reg);
                e0y_next   = EDGE_W'(rdy) - EDGE_W'(ay_reg);
                e0z_next   = EDGE_W'(rdz) - EDGE_W'(az_reg);
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                e1x_next   = EDGE_W'(rdx) - EDGE_W'(ax_reg);
                e1y_next   = EDGE_W'(rdy) - EDGE_W'(ay_reg);
                e1z_next   = EDGE_W'(rdz) - EDGE_W'(az_reg);
                k_next     = '0;
                n_next[0]  = '0;
                n_next[1]  = '0;
                n_next[2]  = '0;
                state_next = S_TMLD;
            end
            S_TMLD:
            begin
                mcand_next  = PROD_W'(mag_edge(opa));
                mplier_next = mag_edge(opb);
                msign_next  = opa[EDGE_W-1] ^ opb[EDGE_W-1];
                macc_next   = '0;
                mcnt_next   = '0;
                state_next  = S_TMUL;
            end
            S_TMUL:
            begin
                macc_next   = prod_c;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(MAG_W - 1))
                begin
                    n_next[k_reg[2:1]] = n_reg[k_reg[2:1]] + pterm;
                    if (k_reg == 3'd5)
                    begin
                        j_next     = '0;
                        state_next = S_SRD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_TMLD;
                    end
                end
            end
            S_SRD:
            begin
                state_next = S_SWR;
            end
            S_SWR:
            begin
                sum_we = 1'b1;
                j_next = j_reg + 1'b1;
                state_next = (j_reg == 2'd2) ? S_IDLE : S_SRD;
            end
            S_RRD:
            begin
                state_next = S_RMAG;
            end
            S_RMAG:
            begin
                mg_next[0] = mag64(sum_rd_reg[SUM_W-1:0]);
                mg_next[1] = mag64(sum_rd_reg[2*SUM_W-1:SUM_W]);
                mg_next[2] = mag64(sum_rd_reg[3*SUM_W-1:2*SUM_W]);
                sg_next    = {sum_rd_reg[3*SUM_W-1], sum_rd_reg[2*SUM_W-1],
                              sum_rd_reg[SUM_W-1]};
                if (sum_rd_reg == '0)
                begin
                    done_next  = 1'b1;
                    fb_next    = 1'b1;
                    oor_next   = 1'b0;
                    o_next[0]  = '0;
                    o_next[1]  = NORM_W'(ONE_Q14);
                    o_next[2]  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (mmax[SUM_W-1:MAG_W] != '0)
                begin
                    mg_next[0] = mg_reg[0] >> 1;
                    mg_next[1] = mg_reg[1] >> 1;
                    mg_next[2] = mg_reg[2] >> 1;
                end
                else if (!mmax[MAG_W-1])
                begin
                    mg_next[0] = mg_reg[0] << 1;
                    mg_next[1] = mg_reg[1] << 1;
                    mg_next[2] = mg_reg[2] << 1;
                end
                else
                begin
                    k_next     = '0;
                    v_next     = '0;
                    state_next = S_SLD;
                end
            end
            S_SLD:
            begin
                mcand_next  = PROD_W'(mg_sel[MAG_W-1:0]);
                mplier_next = mg_sel[MAG_W-1:0];
                msign_next  = 1'b0;
                macc_next   = '0;
                mcnt_next   = '0;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                macc_next   = prod_c;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(MAG_W - 1))
                begin
                    v_next = v_reg + SUM_W'(prod_c);
                    if (k_reg == 3'd2)
                    begin
                        res_next   = '0;
                        bit_next   = SUM_W'(1) << (SUM_W - 2);
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_SLD;
                    end
                end
            end
            S_SQRT:
            begin
                if (v_reg >= strial)
                begin
                    v_next   = v_reg - strial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    k_next     = '0;
                    state_next = S_DLD;
                end
            end
            S_DLD:
            begin
                rem_next   = LEN_W'(dnum[NUM_W-1:Q_W]);
                numsh_next = dnum[Q_W-1:0];
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            default:
            begin
                rem_next   = dge ? LEN_W'(dtrial - {1'b0, len}) : LEN_W'(dtrial);
                numsh_next = numsh_reg << 1;
                dcnt_next  = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(Q_W - 1))
                begin
                    o_next[k_reg[1:0]] = sg_reg[k_reg[1:0]] ? -signed'(qo) : signed'(qo);
                    if (k_reg == 3'd2)
                    begin
                        done_next  = 1'b1;
                        fb_next    = 1'b0;
                        oor_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_DLD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[cnt_reg[ADDR_W-1:0]] <= {pos_z, pos_y, pos_x};
        end
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd_reg <= sum_mem[sum_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        cc_reg     <= cc_next;
        idx_reg    <= idx_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        e0x_reg    <= e0x_next;
        e0y_reg    <= e0y_next;
        e0z_reg    <= e0z_next;
        e1x_reg    <= e1x_next;
        e1y_reg    <= e1y_next;
        e1z_reg    <= e1z_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        macc_reg   <= macc_next;
        mcnt_reg   <= mcnt_next;
        msign_reg  <= msign_next;
        n_reg      <= n_next;
        mg_reg     <= mg_next;
        sg_reg     <= sg_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        numsh_reg  <= numsh_next;
        q_reg      <= q_next;
        dcnt_reg   <= dcnt_next;
        o_reg      <= o_next;
        fb_reg     <= fb_next;
        oor_reg    <= oor_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign norm_x        = o_reg[0];
    assign norm_y        = o_reg[1];
    assign norm_z        = o_reg[2];
    assign used_fallback = fb_reg;
    assign out_of_range  = oor_reg;

    `VNA_ASSERT_IMP(a_done_idle, done, !busy)
    `VNA_ASSERT_IMP(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(MAX_VERT))
    `VNA_ASSERT_IMP(a_fallback, done && used_fallback,
                    !out_of_range && norm_y == NORM_W'(ONE_Q14) && norm_x == '0)
    `VNA_ASSERT_IMP(a_oor_zero, done && out_of_range,
                    !used_fallback && norm_x == '0 && norm_y == '0 && norm_z == '0)
    `VNA_ASSERT_NXT(a_div_rem, state_reg == S_DIV, rem_reg < len)
endmodule
`default_nettype wire
